/* sv/lpt_pkg.sv */
// ---------------------------------------------------------------------------
// Long press tracker package
// Shared widths, command codes and controller/datapath command structs.
// ---------------------------------------------------------------------------
package lpt_pkg;

  localparam int unsigned ENTRIES_DEF = 16;
  localparam logic [31:0] LONG_PRESS_FRAMES_RST = 32'd22050;
  localparam logic [2:0]  MAX_USER_KIND = 3'd4;

  typedef enum logic [1:0] {
    CMD_DOWN = 2'd0,
    CMD_UP   = 2'd1,
    CMD_TICK = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  localparam logic EV_RELEASE = 1'b0;
  localparam logic EV_LONG    = 1'b1;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // capture the input word
    logic free_m;    // free the matching entry
    logic insert;    // append a new entry
    logic add;       // add tick frames to all valid counters
    logic scan;      // test the entry at the scan rank
    logic scan_rst;  // restart the rank counter
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic match;     // matching entry found
    logic qualify;   // down event qualifies
    logic fire;      // entry at scan rank fires
    logic scan_end;  // rank counter reached the fill count
  } dp_sts_t;

endpackage

/* sv/lpt_if.sv */
// ---------------------------------------------------------------------------
// Long press tracker channels
// Valid/ready interfaces for the input word and the result word.
// ---------------------------------------------------------------------------
interface lpt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [2:0]  trigger_kind;
  logic [15:0] trigger_id;
  logic        function_present;
  logic        long_capable;
  logic        already_long;
  logic        sustainable;
  logic [7:0]  function_id;
  logic [4:0]  target_track;
  logic [3:0]  target_group;
  logic [15:0] tick_frames;

  modport source (output valid, cmd, trigger_kind, trigger_id, function_present,
                  long_capable, already_long, sustainable, function_id,
                  target_track, target_group, tick_frames, input ready);
  modport sink (input valid, cmd, trigger_kind, trigger_id, function_present,
                long_capable, already_long, sustainable, function_id,
                target_track, target_group, tick_frames, output ready);
endinterface

interface lpt_out_if;
  logic        valid;
  logic        ready;
  logic        event_kind;
  logic        was_long;
  logic [2:0]  out_trigger_kind;
  logic [15:0] out_trigger_id;
  logic [7:0]  out_function_id;
  logic [4:0]  out_track;
  logic [3:0]  out_group;
  logic        last;

  modport source (output valid, event_kind, was_long, out_trigger_kind,
                  out_trigger_id, out_function_id, out_track, out_group, last,
                  input ready);
  modport sink (input valid, event_kind, was_long, out_trigger_kind,
                out_trigger_id, out_function_id, out_track, out_group, last,
                output ready);
endinterface

/* sv/lpt_datapath.sv */
// ---------------------------------------------------------------------------
// Long press tracker datapath
// Entry table, match search, insertion, counters and the ranked scan.
// ---------------------------------------------------------------------------
module lpt_datapath #(
  parameter int unsigned ENTRIES = lpt_pkg::ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [31:0]      frames_thr,
  input  lpt_pkg::dp_cmd_t cmd,
  output lpt_pkg::dp_sts_t sts,
  input  logic [1:0]       in_cmd,
  input  logic [2:0]       in_kind,
  input  logic [15:0]      in_id,
  input  logic             in_fpres,
  input  logic             in_lcap,
  input  logic             in_along,
  input  logic             in_sus,
  input  logic [7:0]       in_func,
  input  logic [4:0]       in_track,
  input  logic [3:0]       in_group,
  input  logic [15:0]      in_tick,
  output logic             o_was_long,
  output logic [2:0]       o_kind,
  output logic [15:0]      o_id,
  output logic [7:0]       o_func,
  output logic [4:0]       o_track,
  output logic [3:0]       o_group
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  // Captured input word.
  logic [1:0]  cmd_r;
  logic [2:0]  kind_r;
  logic [15:0] id_r;
  logic        fpres_r, lcap_r, along_r, sus_r;
  logic [7:0]  func_r;
  logic [4:0]  track_r;
  logic [3:0]  group_r;
  logic [15:0] tick_r;

  // Entry table.
  logic [ENTRIES-1:0] valid_r;
  logic [2:0]  kind_a  [ENTRIES];
  logic [15:0] id_a    [ENTRIES];
  logic [7:0]  func_a  [ENTRIES];
  logic [4:0]  track_a [ENTRIES];
  logic [3:0]  group_a [ENTRIES];
  logic [31:0] count_a [ENTRIES];
  logic        long_a  [ENTRIES];
  logic [IW-1:0] order_a [ENTRIES];
  logic [CW-1:0] used_r;

  // Search results and scan rank.
  logic [IW-1:0] match_idx_r;
  logic          match_r;
  logic [CW-1:0] rank_r;
  logic [IW-1:0] hit_idx_r;
  logic          hit_r;

  // Match, free slot and rank lookups over the table.
  logic [IW-1:0] m_idx, f_idx, r_idx;
  logic          m_hit, f_hit, r_hit;
  always_comb begin
    m_idx = '0; m_hit = 1'b0;
    f_idx = '0; f_hit = 1'b0;
    r_idx = '0; r_hit = 1'b0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && kind_a[i] == kind_r && id_a[i] == id_r) begin
        m_idx = IW'(i); m_hit = 1'b1;
      end
      if (!valid_r[i]) begin
        f_idx = IW'(i); f_hit = 1'b1;
      end
      if (valid_r[i] && CW'(order_a[i]) == rank_r) begin
        r_idx = IW'(i); r_hit = 1'b1;
      end
    end
  end

  // Registered match and rank lookups break the path to the table write.
  always_ff @(posedge clk) begin
    match_idx_r <= m_idx;
    match_r     <= m_hit;
    hit_idx_r   <= r_idx;
    hit_r       <= r_hit;
  end

  logic fire_c;
  assign fire_c = hit_r && !long_a[hit_idx_r] && (count_a[hit_idx_r] > frames_thr);

  assign sts.match    = match_r;
  assign sts.qualify  = fpres_r && (kind_r <= lpt_pkg::MAX_USER_KIND) && lcap_r &&
                        !along_r && sus_r;
  assign sts.fire     = fire_c;
  assign sts.scan_end = (rank_r >= used_r);

  // Result fields come from the matched or scanned entry.
  logic [IW-1:0] sel;
  assign sel        = (cmd_r == lpt_pkg::CMD_TICK) ? hit_idx_r : match_idx_r;
  assign o_was_long = long_a[sel];
  assign o_kind     = kind_a[sel];
  assign o_id       = id_a[sel];
  assign o_func     = func_a[sel];
  assign o_track    = track_a[sel];
  assign o_group    = group_a[sel];

  // Input capture and rank counter.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_cmd; kind_r <= in_kind; id_r <= in_id;
      fpres_r <= in_fpres; lcap_r <= in_lcap; along_r <= in_along;
      sus_r <= in_sus; func_r <= in_func; track_r <= in_track;
      group_r <= in_group; tick_r <= in_tick;
    end
    if (cmd.scan_rst) rank_r <= '0;
    else if (cmd.scan) rank_r <= rank_r + 1'b1;
  end

  // Saturating sums for the tick update.
  logic [32:0] sum_a [ENTRIES];
  always_comb begin
    for (int i = 0; i < ENTRIES; i++)
      sum_a[i] = {1'b0, count_a[i]} + {17'd0, tick_r};
  end

  // Table updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      used_r  <= '0;
    end else begin
      if (cmd.free_m) begin
        valid_r[match_idx_r] <= 1'b0;
        for (int i = 0; i < ENTRIES; i++)
          if (valid_r[i] && order_a[i] > order_a[match_idx_r])
            order_a[i] <= order_a[i] - 1'b1;
        used_r <= used_r - 1'b1;
      end else if (cmd.insert && f_hit) begin
        valid_r[f_idx] <= 1'b1;
        kind_a[f_idx]  <= kind_r;
        id_a[f_idx]    <= id_r;
        func_a[f_idx]  <= func_r;
        track_a[f_idx] <= track_r;
        group_a[f_idx] <= group_r;
        count_a[f_idx] <= '0;
        long_a[f_idx]  <= 1'b0;
        order_a[f_idx] <= IW'(used_r);
        used_r <= used_r + 1'b1;
      end
      if (cmd.add) begin
        for (int i = 0; i < ENTRIES; i++)
          if (valid_r[i]) count_a[i] <= sum_a[i][32] ? 32'hFFFF_FFFF : sum_a[i][31:0];
      end
      if (cmd.scan && fire_c) long_a[hit_idx_r] <= 1'b1;
    end
  end

endmodule

/* sv/lpt_ctrl.sv */
// ---------------------------------------------------------------------------
// Long press tracker controller
// Sequences one input word through search, update, scan and result words.
// ---------------------------------------------------------------------------
module lpt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output lpt_pkg::dp_cmd_t cmd,
  input  lpt_pkg::dp_sts_t sts,
  input  logic [1:0]       cur_cmd,
  output logic             res_load,
  output logic             res_kind,
  output logic             res_last_fix,
  input  logic             out_busy
);

  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_DECIDE, S_LOOK, S_TEST, S_FLUSH
  } state_t;

  state_t state_r, state_nxt;

  // Next state and datapath commands for each state.
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_ready     = 1'b0;
    res_load     = 1'b0;
    res_kind     = lpt_pkg::EV_RELEASE;
    res_last_fix = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: state_nxt = S_DECIDE;
      S_DECIDE: begin
        case (lpt_pkg::cmd_t'(cur_cmd))
          lpt_pkg::CMD_DOWN: begin
            if (!sts.qualify) state_nxt = S_IDLE;
            else if (sts.match) begin
              cmd.free_m = 1'b1;
              state_nxt = S_SEARCH;  // re-search finds no match, then inserts
            end else begin
              cmd.insert = 1'b1;
              state_nxt = S_IDLE;
            end
          end
          lpt_pkg::CMD_UP: begin
            state_nxt = S_IDLE;
            if (sts.match && !out_busy) begin
              res_load = 1'b1;
              res_kind = lpt_pkg::EV_RELEASE;
              cmd.free_m = 1'b1;
            end else if (sts.match) state_nxt = S_DECIDE;
          end
          lpt_pkg::CMD_TICK: begin
            cmd.add = 1'b1;
            cmd.scan_rst = 1'b1;
            state_nxt = S_LOOK;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_LOOK: state_nxt = S_TEST;
      S_TEST: begin
        if (sts.scan_end) begin
          // The held word needs a free output register to close the tick.
          if (!out_busy) begin
            res_last_fix = 1'b1;
            state_nxt = S_FLUSH;
          end
        end else if (!sts.fire) begin
          cmd.scan = 1'b1;
          state_nxt = S_LOOK;
        end else if (!out_busy) begin
          res_load = 1'b1;
          res_kind = lpt_pkg::EV_LONG;
          cmd.scan = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_FLUSH: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

/* sv/long_press_tracker_core.sv */
// ---------------------------------------------------------------------------
// Long press tracker core
// Tracks held triggers and reports releases and long presses.
// ---------------------------------------------------------------------------
// Sequencing: a down or up word passes through search and decide; a tick
// loops look and test over each valid entry and waits on output stalls, one result word per fired entry.
// Throughput is one word at a time, bounded by the rank scan loop.
// Reset: synchronous active-low rst_n empties the table at once and loads
// the threshold with 22050; a held long-press word is sent with last set
// once the scan ends.
module long_press_tracker_core #(
  parameter int unsigned ENTRIES = lpt_pkg::ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  lpt_in_if.sink      in_ch,
  lpt_out_if.source   out_ch
);

  logic [31:0] frames_r;
  always_ff @(posedge clk) begin
    if (!rst_n) frames_r <= lpt_pkg::LONG_PRESS_FRAMES_RST;
    else if (cfg_we) frames_r <= cfg_wdata;
  end

  lpt_pkg::dp_cmd_t dcmd;
  lpt_pkg::dp_sts_t dsts;
  logic        res_load, res_kind, res_last_fix;
  logic        d_wl;
  logic [2:0]  d_kind;
  logic [15:0] d_id;
  logic [7:0]  d_func;
  logic [4:0]  d_track;
  logic [3:0]  d_group;
  logic [1:0]  cur_cmd;

  // Output word registers.
  logic        out_valid_r;
  logic        ev_r, wl_r, last_r;
  logic [2:0]  k_r;
  logic [15:0] i_r;
  logic [7:0]  f_r;
  logic [4:0]  t_r;
  logic [3:0]  g_r;

  // One long-press word is held back so the last one can carry last.
  logic        hold_r;
  logic [2:0]  hk_r;
  logic [15:0] hi_r;
  logic [7:0]  hf_r;
  logic [4:0]  ht_r;
  logic [3:0]  hg_r;

  logic        out_busy;
  assign out_busy = out_valid_r && !out_ch.ready;

  lpt_datapath #(.ENTRIES(ENTRIES)) u_dp (
    .clk, .rst_n, .frames_thr(frames_r), .cmd(dcmd), .sts(dsts),
    .in_cmd(in_ch.cmd), .in_kind(in_ch.trigger_kind), .in_id(in_ch.trigger_id),
    .in_fpres(in_ch.function_present), .in_lcap(in_ch.long_capable),
    .in_along(in_ch.already_long), .in_sus(in_ch.sustainable),
    .in_func(in_ch.function_id), .in_track(in_ch.target_track),
    .in_group(in_ch.target_group), .in_tick(in_ch.tick_frames),
    .o_was_long(d_wl), .o_kind(d_kind), .o_id(d_id), .o_func(d_func),
    .o_track(d_track), .o_group(d_group)
  );

  // The up path needs function_present; remember the command and flag.
  logic [1:0] cmd_cap_r;
  logic       fp_cap_r;
  always_ff @(posedge clk) begin
    if (dcmd.load) begin
      cmd_cap_r <= in_ch.cmd;
      fp_cap_r  <= in_ch.function_present;
    end
  end
  // An up without function is treated as command none.
  assign cur_cmd = (cmd_cap_r == lpt_pkg::CMD_UP && !fp_cap_r) ? lpt_pkg::CMD_NONE
                                                                : cmd_cap_r;

  lpt_ctrl u_ctrl (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .cmd(dcmd), .sts(dsts), .cur_cmd,
    .res_load, .res_kind, .res_last_fix, .out_busy(out_busy)
  );

  // Result staging: releases go out directly, long presses wait in the hold.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      hold_r      <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      if (res_load && res_kind == lpt_pkg::EV_RELEASE) begin
        out_valid_r <= 1'b1;
        ev_r <= lpt_pkg::EV_RELEASE; wl_r <= d_wl; last_r <= 1'b1;
        k_r <= d_kind; i_r <= d_id; f_r <= d_func; t_r <= d_track; g_r <= d_group;
      end else if (res_load) begin
        // A new long press pushes out the held one without last.
        if (hold_r) begin
          out_valid_r <= 1'b1;
          ev_r <= lpt_pkg::EV_LONG; wl_r <= 1'b0; last_r <= 1'b0;
          k_r <= hk_r; i_r <= hi_r; f_r <= hf_r; t_r <= ht_r; g_r <= hg_r;
        end
        hold_r <= 1'b1;
        hk_r <= d_kind; hi_r <= d_id; hf_r <= d_func; ht_r <= d_track; hg_r <= d_group;
      end else if (res_last_fix && hold_r) begin
        out_valid_r <= 1'b1;
        ev_r <= lpt_pkg::EV_LONG; wl_r <= 1'b0; last_r <= 1'b1;
        k_r <= hk_r; i_r <= hi_r; f_r <= hf_r; t_r <= ht_r; g_r <= hg_r;
        hold_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.event_kind       = ev_r;
  assign out_ch.was_long         = wl_r;
  assign out_ch.out_trigger_kind = k_r;
  assign out_ch.out_trigger_id   = i_r;
  assign out_ch.out_function_id  = f_r;
  assign out_ch.out_track        = t_r;
  assign out_ch.out_group        = g_r;
  assign out_ch.last             = last_r;

  // A release word always closes its input.
  a_rel_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.event_kind == lpt_pkg::EV_RELEASE |-> out_ch.last)
    else $error("release word without last");
  // A long-press word never has was_long set.
  a_long_wl: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.event_kind == lpt_pkg::EV_LONG |-> !out_ch.was_long)
    else $error("long press word with was_long set");
  // No input is taken while a result is still held.
  a_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !hold_r)
    else $error("input accepted with a held result");

endmodule

/* bench/lpt_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Long press tracker checker
// Watches both channels, keeps its own copy of the trigger table and the
// threshold, predicts release and long-press words, and compares them.
// ---------------------------------------------------------------------------
module lpt_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  lpt_in_if.sink      in_mon,
  lpt_out_if.sink     out_mon,
  output int          err_count,
  output int          pending_words,
  output int          release_seen,
  output int          long_seen
);

  typedef struct packed {
    logic        event_kind;
    logic        was_long;
    logic [2:0]  kind;
    logic [15:0] id;
    logic [7:0]  func;
    logic [4:0]  track;
    logic [3:0]  group;
    logic        last;
  } press_word_t;

  localparam int NSLOT = lpt_pkg::ENTRIES_DEF;

  logic [31:0] threshold;
  logic        held_valid [NSLOT];
  logic [2:0]  held_kind  [NSLOT];
  logic [15:0] held_id    [NSLOT];
  logic [7:0]  held_func  [NSLOT];
  logic [4:0]  held_track [NSLOT];
  logic [3:0]  held_group [NSLOT];
  logic [31:0] held_count [NSLOT];
  logic        held_long  [NSLOT];
  int          held_rank  [NSLOT];
  int          held_used;
  press_word_t press_queue[$];

  function automatic int find_held(logic [2:0] k, logic [15:0] id);
    for (int i = 0; i < NSLOT; i++)
      if (held_valid[i] && held_kind[i] == k && held_id[i] == id) return i;
    return -1;
  endfunction

  function automatic void release_slot(int s);
    int r;
    r = held_rank[s];
    held_valid[s] = 1'b0;
    for (int i = 0; i < NSLOT; i++)
      if (held_valid[i] && held_rank[i] > r) held_rank[i]--;
    if (held_used > 0) held_used--;
  endfunction

  function automatic press_word_t make_word(int s, logic ev, logic wl);
    press_word_t w;
    w.event_kind = ev;
    w.was_long   = wl;
    w.kind       = held_kind[s];
    w.id         = held_id[s];
    w.func       = held_func[s];
    w.track      = held_track[s];
    w.group      = held_group[s];
    w.last       = 1'b0;
    return w;
  endfunction

  // Update the table for one accepted word and queue the words it causes.
  task automatic predict_word();
    int m;
    int n;
    logic [32:0] sum;
    press_word_t w;
    n = 0;
    case (lpt_pkg::cmd_t'(in_mon.cmd))
      lpt_pkg::CMD_DOWN: begin
        if (in_mon.function_present && in_mon.trigger_kind <= lpt_pkg::MAX_USER_KIND &&
            in_mon.long_capable && !in_mon.already_long && in_mon.sustainable) begin
          m = find_held(in_mon.trigger_kind, in_mon.trigger_id);
          if (m >= 0) release_slot(m);
          for (int i = 0; i < NSLOT; i++) begin
            if (!held_valid[i]) begin
              held_valid[i] = 1'b1;
              held_kind[i]  = in_mon.trigger_kind;
              held_id[i]    = in_mon.trigger_id;
              held_func[i]  = in_mon.function_id;
              held_track[i] = in_mon.target_track;
              held_group[i] = in_mon.target_group;
              held_count[i] = '0;
              held_long[i]  = 1'b0;
              held_rank[i]  = held_used;
              held_used++;
              break;
            end
          end
        end
      end
      lpt_pkg::CMD_UP: begin
        if (in_mon.function_present) begin
          m = find_held(in_mon.trigger_kind, in_mon.trigger_id);
          if (m >= 0) begin
            w = make_word(m, lpt_pkg::EV_RELEASE, held_long[m]);
            w.last = 1'b1;
            press_queue.push_back(w);
            release_slot(m);
          end
        end
      end
      lpt_pkg::CMD_TICK: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (held_valid[i]) begin
            sum = {1'b0, held_count[i]} + {17'd0, in_mon.tick_frames};
            held_count[i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          end
        end
        // Fire in insertion order; the final word of the tick carries last.
        for (int r = 0; r < held_used; r++) begin
          for (int i = 0; i < NSLOT; i++) begin
            if (held_valid[i] && held_rank[i] == r) begin
              if (!held_long[i] && held_count[i] > threshold) begin
                held_long[i] = 1'b1;
                press_queue.push_back(make_word(i, lpt_pkg::EV_LONG, 1'b0));
                n++;
              end
              break;
            end
          end
        end
        if (n > 0) press_queue[$].last = 1'b1;
      end
      default: ;
    endcase
  endtask

  // Compare one result word against the oldest prediction.
  task automatic check_word();
    press_word_t got;
    press_word_t exp_w;
    got = {out_mon.event_kind, out_mon.was_long, out_mon.out_trigger_kind,
           out_mon.out_trigger_id, out_mon.out_function_id, out_mon.out_track,
           out_mon.out_group, out_mon.last};
    if (got.event_kind == lpt_pkg::EV_LONG) long_seen++;
    else release_seen++;
    if (press_queue.size() == 0) begin
      err_count++;
      if (err_count <= 10) $display("%0t: unexpected result word %h", $realtime, got);
    end else begin
      exp_w = press_queue.pop_front();
      if (got !== exp_w) begin
        err_count++;
        if (err_count <= 10) begin
          $display("%0t: mismatch expected ev=%b wl=%b k=%0d id=%h f=%h t=%0d g=%0d l=%b",
                   $realtime, exp_w.event_kind, exp_w.was_long, exp_w.kind, exp_w.id,
                   exp_w.func, exp_w.track, exp_w.group, exp_w.last);
          $display("%0t:          actual ev=%b wl=%b k=%0d id=%h f=%h t=%0d g=%0d l=%b",
                   $realtime, got.event_kind, got.was_long, got.kind, got.id,
                   got.func, got.track, got.group, got.last);
        end
      end
    end
  endtask

  // Sample both channels at the clock edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      threshold = lpt_pkg::LONG_PRESS_FRAMES_RST;
      for (int i = 0; i < NSLOT; i++) held_valid[i] = 1'b0;
      held_used = 0;
      press_queue.delete();
      err_count = 0;
      release_seen = 0;
      long_seen = 0;
    end else begin
      if (cfg_we) threshold = cfg_wdata;
      if (in_mon.valid && in_mon.ready) predict_word();
      if (out_mon.valid && out_mon.ready) check_word();
    end
    pending_words = press_queue.size();
  end

endmodule

/* bench/lpt_bench_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Long press tracker bench helpers
// Small record type the stimulus uses to build one input word.
// ---------------------------------------------------------------------------
package lpt_bench_pkg;
  typedef struct {
    logic [1:0]  cmd;
    logic [2:0]  kind;
    logic [15:0] id;
    logic        fpres;
    logic        lcap;
    logic        along;
    logic        sus;
    logic [7:0]  func;
    logic [4:0]  track;
    logic [3:0]  group;
    logic [15:0] frames;
  } trig_word_t;
endpackage

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Long press tracker testbench
// Drives down, up and tick words with bursty timing and a stalling receiver,
// walks the threshold through several values, and takes the verdict from
// the checker.
// ---------------------------------------------------------------------------
module testbench;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  int          err_count;
  int          pending_words;
  int          release_seen;
  int          long_seen;
  int          words_sent = 0;
  int          hold_off;
  logic        hold_tgl = 1'b0;
  logic        hold_seen;
  logic        stall_phase = 1'b0;

  lpt_in_if  in_ch ();
  lpt_out_if out_ch ();

  long_press_tracker_core u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  lpt_checker u_check (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_mon(in_ch.sink), .out_mon(out_ch.sink), .err_count(err_count),
    .pending_words(pending_words), .release_seen(release_seen),
    .long_seen(long_seen)
  );

  always #5 clk = ~clk;

  // Receiver: long hold-off when asked, otherwise a stall pattern of its own.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_seen <= hold_tgl;
      hold_off <= 0;
    end else if (hold_tgl != hold_seen) begin
      hold_seen <= hold_tgl;
      hold_off <= 300;
      out_ch.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ch.ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 40) == 0) stall_phase <= ~stall_phase;
      out_ch.ready <= stall_phase ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  // Offer one word and hold it until the block takes it.
  task automatic send_word(lpt_bench_pkg::trig_word_t w);
    in_ch.valid <= 1'b1;
    in_ch.cmd <= w.cmd;
    in_ch.trigger_kind <= w.kind;
    in_ch.trigger_id <= w.id;
    in_ch.function_present <= w.fpres;
    in_ch.long_capable <= w.lcap;
    in_ch.already_long <= w.along;
    in_ch.sustainable <= w.sus;
    in_ch.function_id <= w.func;
    in_ch.target_track <= w.track;
    in_ch.target_group <= w.group;
    in_ch.tick_frames <= w.frames;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
  endtask

  task automatic idle_cycles(int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic lpt_bench_pkg::trig_word_t qual_down(logic [2:0] k, logic [15:0] id);
    lpt_bench_pkg::trig_word_t w;
    w.cmd = lpt_pkg::CMD_DOWN; w.kind = k; w.id = id;
    w.fpres = 1'b1; w.lcap = 1'b1; w.along = 1'b0; w.sus = 1'b1;
    w.func = 8'($urandom); w.track = 5'($urandom); w.group = 4'($urandom);
    w.frames = 16'($urandom);
    return w;
  endfunction

  function automatic lpt_bench_pkg::trig_word_t up_word(logic [2:0] k, logic [15:0] id);
    lpt_bench_pkg::trig_word_t w;
    w = qual_down(k, id);
    w.cmd = lpt_pkg::CMD_UP;
    w.lcap = 1'($urandom); w.along = 1'($urandom); w.sus = 1'($urandom);
    return w;
  endfunction

  function automatic lpt_bench_pkg::trig_word_t tick_word(logic [15:0] f);
    lpt_bench_pkg::trig_word_t w;
    w = qual_down(3'($urandom), 16'($urandom));
    w.cmd = lpt_pkg::CMD_TICK; w.frames = f;
    return w;
  endfunction

  // Drain all expected words, then let the block settle before a write.
  task automatic quiesce_and_write(logic [31:0] value);
    idle_cycles(1);
    while (pending_words != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int count, int id_span, int tick_max);
    lpt_bench_pkg::trig_word_t w;
    int burst;
    int sel;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 12));
        burst = $urandom_range(1, 20);
      end
      burst--;
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        w = qual_down(3'($urandom_range(0, 4)), 16'($urandom_range(0, id_span)));
      end else if (sel < 65) begin
        w = up_word(3'($urandom_range(0, 4)), 16'($urandom_range(0, id_span)));
        if ($urandom_range(0, 9) == 0) w.fpres = 1'b0;
      end else if (sel < 90) begin
        w = tick_word(16'($urandom_range(0, tick_max)));
      end else begin
        // Noise: random fields, malformed downs and the unused command.
        w = qual_down(3'($urandom), 16'($urandom));
        w.cmd = 2'($urandom); w.fpres = 1'($urandom); w.lcap = 1'($urandom);
        w.along = 1'($urandom); w.sus = 1'($urandom); w.frames = 16'($urandom);
      end
      send_word(w);
    end
    idle_cycles(1);
  endtask

  initial begin : stimulus
    lpt_bench_pkg::trig_word_t w;
    in_ch.valid <= 1'b0;
    in_ch.cmd <= lpt_pkg::CMD_NONE;
    in_ch.trigger_kind <= '0;
    in_ch.trigger_id <= '0;
    in_ch.function_present <= 1'b0;
    in_ch.long_capable <= 1'b0;
    in_ch.already_long <= 1'b0;
    in_ch.sustainable <= 1'b0;
    in_ch.function_id <= '0;
    in_ch.target_track <= '0;
    in_ch.target_group <= '0;
    in_ch.tick_frames <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: extremes, qualification failures, the unused command, misses.
    send_word(qual_down(3'd0, 16'h0000));
    send_word(qual_down(3'd4, 16'hFFFF));
    w = qual_down(3'd5, 16'h1234); send_word(w);
    w = qual_down(3'd1, 16'h1); w.fpres = 1'b0; send_word(w);
    w = qual_down(3'd1, 16'h2); w.lcap = 1'b0; send_word(w);
    w = qual_down(3'd1, 16'h3); w.along = 1'b1; send_word(w);
    w = qual_down(3'd1, 16'h4); w.sus = 1'b0; send_word(w);
    w = qual_down(3'd2, 16'h5); w.cmd = lpt_pkg::CMD_NONE; send_word(w);
    send_word(qual_down(3'd0, 16'h0000));        // re-press frees the old entry
    send_word(tick_word(16'hFFFF));
    send_word(tick_word(16'h0000));
    w = up_word(3'd4, 16'hFFFF); w.fpres = 1'b0; send_word(w);
    send_word(up_word(3'd4, 16'hFFFF));
    send_word(up_word(3'd7, 16'h1234));          // no matching entry
    send_word(up_word(3'd0, 16'h0000));
    for (int i = 0; i < 17; i++) send_word(qual_down(3'(i % 5), 16'(16'h100 + i)));
    send_word(tick_word(16'd5));
    idle_cycles(1);

    // Table full: a new press is dropped.
    quiesce_and_write(32'd0);
    send_word(tick_word(16'd1));
    send_word(qual_down(3'd2, 16'hABCD));
    send_word(up_word(3'd2, 16'hABCD));

    // Fill the output path while the receiver holds off.
    @(posedge clk);
    hold_tgl <= ~hold_tgl;
    for (int i = 0; i < 16; i++) send_word(up_word(3'(i % 5), 16'(16'h100 + i)));
    for (int i = 0; i < 16; i++) send_word(qual_down(3'(i % 5), 16'(16'h200 + i)));
    send_word(tick_word(16'd3));
    send_word(tick_word(16'd3));

    // Largest threshold: fresh presses are counted but never fire.
    quiesce_and_write(32'hFFFF_FFFF);
    for (int i = 0; i < 16; i++) send_word(up_word(3'(i % 5), 16'(16'h200 + i)));
    for (int i = 0; i < 16; i++) send_word(qual_down(3'(i % 5), 16'(16'h300 + i)));
    repeat (40) send_word(tick_word(16'hFFFF));
    for (int i = 0; i < 16; i++) send_word(up_word(3'(i % 5), 16'(16'h300 + i)));

    // Random phases at several thresholds.
    quiesce_and_write(lpt_pkg::LONG_PRESS_FRAMES_RST);
    random_phase(100, 12, 65535);
    quiesce_and_write(32'd1000);
    random_phase(100, 12, 400);
    quiesce_and_write($urandom_range(0, 100000));
    random_phase(100, 40, 30000);

    idle_cycles(1);
    while (pending_words != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d words; saw %0d release and %0d long-press results.",
             words_sent, release_seen, long_seen);
    $display("Thresholds covered zero, the reset value, midrange and the maximum.");
    if (err_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : watchdog
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
